@@ src/variable_partition_allocator_macros.svh @@
// Assertion macros for the partition allocator
`ifndef VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset
`define VPA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vpa check failed");
// Next-cycle implication checked outside reset
`define VPA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vpa check failed");
`endif

@@ src/vpa_pkg.sv @@
// ---------------------------------------------------------------------------
// vpa_pkg
// Shared types and codes for the variable partition allocator.
// ---------------------------------------------------------------------------
package vpa_pkg;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FIT    = 2'd1;
   localparam logic [1:0] ST_NO_OWNER  = 2'd2;
   localparam logic [1:0] ST_TABLE_FULL = 2'd3;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic REG_FIT_POLICY  = 1'b0;
   localparam logic REG_MEMORY_SIZE = 1'b1;

   localparam logic [15:0] MEMORY_SIZE_RESET = 16'd100;

   typedef struct packed {
      logic        action;
      logic [15:0] owner_id;
      logic [15:0] request_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] start_address;
   } rsp_type;

   typedef struct packed {
      logic        free;
      logic [15:0] owner;
      logic [15:0] start;
      logic [15:0] length;
   } seg_type;

endpackage

@@ src/variable_partition_allocator.sv @@
// The scan visits one entry per cycle (up to SEGMENTS), then a shift pass moves one entry
// per cycle to open a slot for a split or to close the gap after a merge.
// Throughput: one request at a time; req_stall stays high until the response is taken, so
// the next request is accepted in the cycle after the response is taken at the earliest.
// Reset (synchronous) gives fit_policy 0 and one free segment of 100 units.
// ---------------------------------------------------------------------------
// variable_partition_allocator
// Segment table allocator with first, best and worst fit, sequenced one entry per cycle.
// ---------------------------------------------------------------------------
module variable_partition_allocator #(
   parameter int SEGMENTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vpa_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [15:0]      csr_data
);
   import vpa_pkg::*;
`include "variable_partition_allocator_macros.svh"

   localparam int IW = $clog2(SEGMENTS);
   localparam int CW = $clog2(SEGMENTS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_SHIFT_UP, S_SHIFT_DN, S_MERGE, S_DONE
   } state_type;

   seg_type          tab_ff [SEGMENTS];
   logic [CW-1:0]    count_ff;
   logic [1:0]       policy_ff;
   state_type        state_ff;
   req_type          req_ff;
   logic [CW-1:0]    idx_ff;
   logic [IW-1:0]    pick_ff;
   logic             found_ff;
   logic [15:0]      pick_len_ff;
   logic [IW-1:0]    rm_ff;
   logic             merge_prev_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   seg_type          cur;
   logic             match;
   logic             better;

   // Current scan entry and the comparison unit
   always_comb begin
      cur    = tab_ff[idx_ff[IW-1:0]];
      match  = 1'b0;
      better = 1'b0;
      if (req_ff.action == ACT_ALLOC) begin
         match = cur.free && (cur.length >= req_ff.request_length);
         case (policy_ff)
            POL_BEST:  better = !found_ff || (cur.length < pick_len_ff);
            POL_WORST: better = !found_ff || (cur.length > pick_len_ff);
            default:   better = !found_ff;
         endcase
      end else begin
         match  = !cur.free && (cur.owner == req_ff.owner_id);
         better = !found_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer, table and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= POL_FIRST;
         count_ff     <= CW'(1);
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         for (int i = 1; i < SEGMENTS; i++) begin
            tab_ff[i] <= '0;
         end
         tab_ff[0] <= '{free: 1'b1, owner: 16'd0, start: 16'd0,
                        length: MEMORY_SIZE_RESET};
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // Take configuration writes; size reinitialises the table
         if (csr_write) begin
            if (csr_index == REG_FIT_POLICY) begin
               policy_ff <= csr_data[1:0];
            end else begin
               count_ff <= CW'(1);
               for (int i = 1; i < SEGMENTS; i++) begin
                  tab_ff[i] <= '0;
               end
               tab_ff[0] <= '{free: 1'b1, owner: 16'd0, start: 16'd0, length: csr_data};
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff   <= req_data;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  pick_ff  <= '0;
                  state_ff <= S_SCAN;
               end
            end
            // Visit one entry per cycle
            S_SCAN: begin
               if (idx_ff >= count_ff) begin
                  state_ff <= S_DECIDE;
               end else begin
                  if (match && better) begin
                     found_ff    <= 1'b1;
                     pick_ff     <= idx_ff[IW-1:0];
                     pick_len_ff <= cur.length;
                  end
                  if ((match && better && !found_ff &&
                       (req_ff.action == ACT_RELEASE ||
                        (policy_ff != POL_BEST && policy_ff != POL_WORST))) ||
                      idx_ff == CW'(SEGMENTS - 1)) begin
                     state_ff <= S_DECIDE;
                  end
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_DECIDE: begin
               if (req_ff.action == ACT_ALLOC) begin
                  if (!found_ff || req_ff.request_length == 16'd0) begin
                     rsp_ff.status        <= ST_NO_FIT;
                     rsp_ff.start_address <= 16'd0;
                     state_ff             <= S_DONE;
                  end else if (pick_len_ff == req_ff.request_length) begin
                     tab_ff[pick_ff].free  <= 1'b0;
                     tab_ff[pick_ff].owner <= req_ff.owner_id;
                     rsp_ff.status         <= ST_OK;
                     rsp_ff.start_address  <= tab_ff[pick_ff].start;
                     state_ff              <= S_DONE;
                  end else if (count_ff >= CW'(SEGMENTS)) begin
                     rsp_ff.status        <= ST_TABLE_FULL;
                     rsp_ff.start_address <= 16'd0;
                     state_ff             <= S_DONE;
                  end else begin
                     rsp_ff.status        <= ST_OK;
                     rsp_ff.start_address <= tab_ff[pick_ff].start;
                     idx_ff               <= count_ff;
                     state_ff             <= S_SHIFT_UP;
                  end
               end else if (!found_ff) begin
                  rsp_ff.status        <= ST_NO_OWNER;
                  rsp_ff.start_address <= 16'd0;
                  state_ff             <= S_DONE;
               end else begin
                  rsp_ff.status        <= ST_OK;
                  rsp_ff.start_address <= tab_ff[pick_ff].start;
                  tab_ff[pick_ff].free  <= 1'b1;
                  tab_ff[pick_ff].owner <= 16'd0;
                  merge_prev_ff        <= 1'b0;
                  state_ff             <= S_MERGE;
               end
            end
            // Open a slot above the pick, one entry per cycle
            S_SHIFT_UP: begin
               if (idx_ff[IW-1:0] > pick_ff) begin
                  tab_ff[idx_ff[IW-1:0]] <= tab_ff[idx_ff[IW-1:0] - IW'(1)];
                  idx_ff                 <= idx_ff - CW'(1);
               end else begin
                  tab_ff[pick_ff].free   <= 1'b0;
                  tab_ff[pick_ff].owner  <= req_ff.owner_id;
                  tab_ff[pick_ff].length <= req_ff.request_length;
                  tab_ff[pick_ff + IW'(1)].start <=
                     tab_ff[pick_ff].start + req_ff.request_length;
                  tab_ff[pick_ff + IW'(1)].length <=
                     tab_ff[pick_ff].length - req_ff.request_length;
                  count_ff <= count_ff + CW'(1);
                  state_ff <= S_DONE;
               end
            end
            // Merge with the next then the previous free neighbour
            S_MERGE: begin
               if (!merge_prev_ff) begin
                  merge_prev_ff <= 1'b1;
                  if (CW'(pick_ff) + CW'(1) < count_ff &&
                      tab_ff[pick_ff + IW'(1)].free) begin
                     tab_ff[pick_ff].length <= tab_ff[pick_ff].length +
                                               tab_ff[pick_ff + IW'(1)].length;
                     rm_ff    <= pick_ff + IW'(1);
                     idx_ff   <= CW'(pick_ff) + CW'(1);
                     state_ff <= S_SHIFT_DN;
                  end
               end else begin
                  if (pick_ff != '0 && tab_ff[pick_ff - IW'(1)].free) begin
                     tab_ff[pick_ff - IW'(1)].length <=
                        tab_ff[pick_ff - IW'(1)].length + tab_ff[pick_ff].length;
                     rm_ff    <= pick_ff;
                     idx_ff   <= CW'(pick_ff);
                     state_ff <= S_SHIFT_DN;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            // Close the gap at rm_ff, one entry per cycle
            S_SHIFT_DN: begin
               if (idx_ff + CW'(1) < count_ff) begin
                  tab_ff[idx_ff[IW-1:0]] <= tab_ff[idx_ff[IW-1:0] + IW'(1)];
                  idx_ff                 <= idx_ff + CW'(1);
               end else begin
                  tab_ff[idx_ff[IW-1:0]] <= '0;
                  count_ff <= count_ff - CW'(1);
                  if (rm_ff != pick_ff) begin
                     state_ff <= S_MERGE;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Checks
   `VPA_ASSERT_IMPL(a_count_range, 1'b1, count_ff >= CW'(1) && count_ff <= CW'(SEGMENTS))
   `VPA_ASSERT_NEXT(a_done_resp, state_ff == S_DONE, rsp_valid_ff)
   `VPA_ASSERT_IMPL(a_busy_stall, state_ff != S_IDLE, req_stall)

endmodule
